@@ src/smd_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Constants, payload types and round helpers shared by the digest core.
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam logic [31:0] PadWord    = 32'h8000_0000;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_h0;
      logic [31:0] digest_h1;
      logic [31:0] digest_h2;
      logic [31:0] digest_h3;
      logic [31:0] digest_h4;
   } rsp_type;

   // one word for the back end: data, and whether it closes a block / a message
   typedef struct packed {
      logic [31:0] word;
      logic        block_end;
      logic        msg_end;
   } cmd_type;

   localparam word_type Iv [5] = '{32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE,
                                   32'h1032_5476, 32'hC3D2_E1F0};

   function automatic word_type round_const(input logic [6:0] t);
      word_type k;
      if (t < 7'd20)      k = 32'h5A82_7999;
      else if (t < 7'd40) k = 32'h6ED9_EBA1;
      else if (t < 7'd60) k = 32'h8F1B_BCDC;
      else                k = 32'hCA62_C1D6;
      return k;
   endfunction

   function automatic word_type round_fn(input logic [6:0] t, input word_type b,
                                         input word_type c, input word_type d);
      word_type f;
      if (t < 7'd20)      f = d ^ (b & (c ^ d));
      else if (t < 7'd40) f = b ^ c ^ d;
      else if (t < 7'd60) f = (b & c) | (d & (b | c));
      else                f = b ^ c ^ d;
      return f;
   endfunction

endpackage

@@ src/smd_if.sv @@
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface smd_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/sha1_message_digest_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Word-serial SHA-1 with padding, length count and digest output.
// ----------------------------------------------------------------------------
// Words are accepted one a cycle while the block is being gathered, as long as
// the queue to the back end has room; a full block then runs through the single
// round unit and the chaining add before the back end takes the next block.
// After the last word the front end emits pad and length words one a cycle while
// the queue accepts them, and the digest is held until taken.
module sha1_message_digest_core
   import smd_pkg::*;
#(
   parameter int unsigned QDepth = QueueDepth
)(
   input  logic clock,
   input  logic reset,
   smd_if.sink   req,
   smd_if.source rsp
);
   logic    f_valid, f_ready, b_valid, b_ready;
   cmd_type f_cmd, b_cmd;

   smd_front u_front (.clock, .reset, .req,
      .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready));

   smd_queue #(.Depth(QDepth)) u_queue (.clock, .reset,
      .in_valid(f_valid), .in_cmd(f_cmd), .in_ready(f_ready),
      .out_valid(b_valid), .out_cmd(b_cmd), .out_ready(b_ready));

   smd_back u_back (.clock, .reset,
      .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready), .rsp);

endmodule

@@ src/smd_front.sv @@
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts message words, counts the length, and emits padded block words.
// ----------------------------------------------------------------------------
module smd_front
   import smd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   smd_if.sink          req,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_ready
);

   localparam logic [1:0] StData = 2'd0;
   localparam logic [1:0] StPad  = 2'd1;
   localparam logic [1:0] StLen  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic        pad_ff, pad_in;     // pad word still owed (full last word)
   logic [2:0]  nb;
   word_type    keep, tail;
   logic        fire, emit;

   assign nb   = (req.payload.valid_bytes > 3'd4) ? 3'd4 : req.payload.valid_bytes;
   assign keep = (nb == 3'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - {nb, 3'b000}));
   assign tail = (req.payload.data_word & keep) | (PadWord >> {nb, 3'b000});

   assign req.ready = (state_ff == StData) && cmd_ready;
   assign fire      = req.valid && req.ready;
   assign emit      = cmd_valid && cmd_ready;

   always_comb begin
      cmd_valid     = 1'b0;
      cmd.word      = 32'h0;
      cmd.msg_end   = 1'b0;
      case (state_ff)
         StData: begin
            cmd_valid = req.valid;
            cmd.word  = (req.payload.last_word && nb != 3'd4) ? tail
                                                               : req.payload.data_word;
         end
         StPad: begin
            cmd_valid = 1'b1;
            if (pad_ff)             cmd.word = PadWord;
            else if (pos_ff == 4'd14) cmd.word = len_ff[63:32];
         end
         default: begin
            cmd_valid = 1'b1;
            cmd.word  = len_ff[31:0];
            cmd.msg_end = 1'b1;
         end
      endcase
      cmd.block_end = (pos_ff == 4'd15);
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      pad_in   = pad_ff;
      if (fire) begin
         pos_in = pos_ff + 4'd1;
         if (req.payload.last_word) begin
            len_in   = len_ff + {58'd0, nb, 3'b000};
            pad_in   = (nb == 3'd4);
            state_in = StPad;
         end else begin
            len_in = len_ff + 64'd32;
         end
      end else if (emit) begin
         pos_in = pos_ff + 4'd1;
         pad_in = 1'b0;
         if (cmd.msg_end) begin
            state_in = StData;
            len_in   = 64'd0;
            pos_in   = 4'd0;
         end else if (state_ff == StPad && !pad_ff && pos_ff == 4'd14) begin
            state_in = StLen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StData;
         pos_ff   <= 4'd0;
         len_ff   <= 64'd0;
         pad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         pad_ff   <= pad_in;
      end
   end

   a_len_last: assert property (@(posedge clock) disable iff (reset)
      emit && cmd.msg_end |-> pos_ff == 4'd15) else $error("length not at block end");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      emit && cmd.msg_end |=> pos_ff == 4'd0 && len_ff == 64'd0)
      else $error("message state not cleared");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != StData |-> !req.ready) else $error("input taken while padding");

endmodule

@@ src/smd_queue.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module smd_queue
   import smd_pkg::*;
#(
   parameter int unsigned Depth = QueueDepth
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cmd_type in_cmd,
   output logic    in_ready,
   output logic    out_valid,
   output cmd_type out_cmd,
   input  logic    out_ready
);
   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

   cmd_type           mem_ff [Depth];
   logic [Aw-1:0]     wr_ff, rd_ff;
   logic [Aw:0]       cnt_ff;
   logic              push, pop;

   assign in_ready  = (cnt_ff != Depth[Aw:0]);
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == Aw'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == Aw'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (Aw+1)'(push) - (Aw+1)'(pop);
      end
   end

   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Depth[Aw:0]) else $error("queue count out of range");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      !in_ready && !pop |=> !in_ready) else $error("full queue drained without pop");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid && !push |=> !out_valid) else $error("empty queue filled without push");

endmodule

@@ src/smd_back.sv @@
// ----------------------------------------------------------------------------
// SHA-1 back end
// Gathers block words and runs the 80-round compression, one round a cycle.
// ----------------------------------------------------------------------------
module smd_back
   import smd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_ready,
   smd_if.source   rsp
);
   localparam logic [1:0] StLoad  = 2'd0;
   localparam logic [1:0] StRound = 2'd1;
   localparam logic [1:0] StAdd   = 2'd2;
   localparam logic [1:0] StOut   = 2'd3;

   logic [1:0] state_ff, state_in;
   word_type   w_ff [16];
   word_type   h_ff [5];
   word_type   v_ff [5];
   logic [6:0] t_ff;
   logic       fin_ff;
   rsp_type    rsp_ff;
   logic       take;
   word_type   wt, tmp;

   assign cmd_ready = (state_ff == StLoad);
   assign take      = cmd_valid && cmd_ready;
   assign rsp.valid   = (state_ff == StOut);
   assign rsp.payload = rsp_ff;

   // w_ff is a shift line: w_ff[0] is the current schedule word while t < 16, W[t-16] after
   assign wt  = (t_ff < 7'd16) ? w_ff[0]
              : {w_ff[13][30:0] ^ w_ff[8][30:0] ^ w_ff[2][30:0] ^ w_ff[0][30:0],
                 w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};
   assign tmp = {v_ff[0][26:0], v_ff[0][31:27]} + round_fn(t_ff, v_ff[1], v_ff[2], v_ff[3])
              + v_ff[4] + wt + round_const(t_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StLoad:  if (take && cmd.block_end) state_in = StRound;
         StRound: if (t_ff == 7'd79) state_in = StAdd;
         StAdd:   state_in = fin_ff ? StOut : StLoad;
         default: if (rsp.ready) state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         t_ff     <= 7'd0;
         fin_ff   <= 1'b0;
         for (int i = 0; i < 5; i++) h_ff[i] <= Iv[i];
      end else begin
         state_ff <= state_in;
         case (state_ff)
            StLoad: if (take) begin
               fin_ff <= cmd.msg_end;
               t_ff   <= 7'd0;
            end
            StRound: t_ff <= t_ff + 7'd1;
            StAdd: begin
               if (fin_ff) for (int i = 0; i < 5; i++) h_ff[i] <= Iv[i];
               else        for (int i = 0; i < 5; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StLoad && take) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= cmd.word;
         if (cmd.block_end) for (int i = 0; i < 5; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == StRound) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wt;
         v_ff[4] <= v_ff[3];
         v_ff[3] <= v_ff[2];
         v_ff[2] <= {v_ff[1][1:0], v_ff[1][31:2]};
         v_ff[1] <= v_ff[0];
         v_ff[0] <= tmp;
      end
      if (state_ff == StAdd) begin
         rsp_ff.digest_h0 <= h_ff[0] + v_ff[0];
         rsp_ff.digest_h1 <= h_ff[1] + v_ff[1];
         rsp_ff.digest_h2 <= h_ff[2] + v_ff[2];
         rsp_ff.digest_h3 <= h_ff[3] + v_ff[3];
         rsp_ff.digest_h4 <= h_ff[4] + v_ff[4];
      end
   end

   a_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == StRound |-> t_ff <= 7'd79) else $error("round index overrun");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("digest dropped");
   a_add_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == StAdd |-> $past(t_ff) == 7'd79) else $error("add before round 79");

endmodule
